// ===== sv/prlh_pkg.sv =====
// Package for the per-peer RTT log2 histogram block.
// Holds the transaction payload types, status codes and fixed constants.
`timescale 1ns / 1ps

package prlh_pkg;

  localparam int BUCKET_W = 5;
  localparam int RTT_US_W = 35;
  localparam int RAW_BKT_W = 6;
  localparam int KEY_W = 112;
  localparam logic [31:0] LOOPBACK_ADDR = 32'h0100007F;

  localparam logic [1:0] ST_DROP = 2'd0;
  localparam logic [1:0] ST_UPDATE = 2'd1;
  localparam logic [1:0] ST_INSERT = 2'd2;
  localparam logic [1:0] ST_EVICT = 2'd3;

  typedef struct packed {
    logic [63:0] group_id;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
    logic [31:0] smoothed_rtt;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [BUCKET_W-1:0] bucket;
    logic [63:0]         sample_count;
    logic [63:0]         rtt_sum_us;
  } out_t;

  typedef struct packed {
    logic                 drop;
    logic [RAW_BKT_W-1:0] bucket_raw;
    logic [RTT_US_W-1:0]  rtt_us;
  } prep_t;

endpackage

// ===== sv/prlh_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module prlh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/prlh_prep.sv =====
// Sample qualification: drop test, scaling to microseconds and raw log2 bucket.
// Depends on prlh_pkg.
`timescale 1ns / 1ps

module prlh_prep
  import prlh_pkg::*;
(
  input  in_t   req,
  output prep_t prep
);

  logic [RAW_BKT_W-1:0] msb_pos;

  // Position of the leading one of the smoothed RTT.
  always_comb begin
    msb_pos = '0;
    for (int i = 0; i < 32; i++) begin
      if (req.smoothed_rtt[i]) begin
        msb_pos = RAW_BKT_W'(i);
      end
    end
  end

  // Multiplying by eight shifts the leading one up by three places.
  assign prep.drop = (req.smoothed_rtt == '0) || (req.peer_address == '0) ||
                     (req.peer_address == LOOPBACK_ADDR);
  assign prep.bucket_raw = msb_pos + RAW_BKT_W'(3);
  assign prep.rtt_us = {req.smoothed_rtt, 3'b000};

endmodule

// ===== sv/per_peer_rtt_log2_histogram.sv =====
// Per-peer RTT log2 histogram with an exactly LRU-managed, fully associative key table.
// A dropped sample goes straight from preparation to the result; a hit scans the keys, updates
// and sweeps the LRU ranks, and a miss scans, clears a row and sweeps; each may also wait for a stalled result.
// One transaction at a time: in_stall is low only in idle, which is entered as the result is registered.
// The key scan and the LRU rank sweep each read one entry per cycle; an insertion clears its row.
// Reset clears the valid bits, then a pass loads each LRU rank with its index.
`timescale 1ns / 1ps

module per_peer_rtt_log2_histogram
  import prlh_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int HIST_BUCKETS = 27
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int BKT_W = $clog2(HIST_BUCKETS);
  localparam int BA_W = $clog2(TABLE_ENTRIES * HIST_BUCKETS);
  localparam int STAT_W = 128;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_PREP, S_SCAN, S_RD, S_UPD, S_CLR, S_LRU, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  in_t                  req_r, req_nxt;
  prep_t                prep;
  logic [BKT_W-1:0]     bucket_r, bucket_nxt;
  logic [RTT_US_W-1:0]  rtt_r, rtt_nxt;
  logic [IDX_W:0]       scan_cnt_r, scan_cnt_nxt;
  logic                 cmp_en_r, cmp_en_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                 hit_r, hit_nxt;
  logic [IDX_W-1:0]     hit_slot_r, hit_slot_nxt;
  logic [IDX_W-1:0]     old_rank_r, old_rank_nxt;
  logic [IDX_W-1:0]     victim_r, victim_nxt;
  logic                 victim_valid_r, victim_valid_nxt;
  logic [BKT_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [63:0]          res_samples_r, res_samples_nxt;
  logic [63:0]          res_sum_r, res_sum_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r, out_data_nxt;

  logic [IDX_W-1:0]     slot_sel;
  logic [IDX_W-1:0]     promo_rank;
  logic [BA_W-1:0]      row_base;
  logic [KEY_W-1:0]     key_word;

  logic                 key_we;
  logic [IDX_W-1:0]     key_raddr;
  logic [KEY_W-1:0]     key_rdata;
  logic                 rank_we;
  logic [IDX_W-1:0]     rank_waddr, rank_wdata, rank_rdata;
  logic                 stat_we;
  logic [STAT_W-1:0]    stat_wdata, stat_rdata;
  logic                 bkt_we;
  logic [BA_W-1:0]      bkt_waddr, bkt_raddr;
  logic [63:0]          bkt_wdata, bkt_rdata;

  prlh_prep u_prep (
    .req  (req_r),
    .prep (prep)
  );

  // Key table: group id above port above address.
  prlh_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (slot_sel),
    .wdata (key_word),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // LRU ranks, read alongside the keys during the scan and rewritten by the sweep.
  prlh_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_ENTRIES)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .raddr (key_raddr),
    .rdata (rank_rdata)
  );

  // Per-entry sample count above microsecond sum.
  prlh_ram #(.WIDTH(STAT_W), .DEPTH(TABLE_ENTRIES)) u_stat_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (slot_sel),
    .wdata (stat_wdata),
    .raddr (slot_sel),
    .rdata (stat_rdata)
  );

  // Histogram rows, one row of HIST_BUCKETS counters per table entry.
  prlh_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES * HIST_BUCKETS)) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (bkt_raddr),
    .rdata (bkt_rdata)
  );

  assign key_word = {req_r.group_id, req_r.peer_port, req_r.peer_address};
  assign slot_sel = hit_r ? hit_slot_r : victim_r;
  // On a miss the victim holds the oldest rank, so every other entry ages by one.
  assign promo_rank = hit_r ? old_rank_r : IDX_W'(TABLE_ENTRIES - 1);
  assign row_base = BA_W'(32'(slot_sel) * HIST_BUCKETS);

  assign key_raddr = scan_cnt_r[IDX_W-1:0];
  assign key_we = (state_r == S_CLR) && (clr_cnt_r == '0);

  // The reset pass writes rank i to entry i. The sweep writes each entry in the cycle
  // after reading it, so a read never meets a write to the same entry.
  assign rank_we = (state_r == S_INIT) || ((state_r == S_LRU) && cmp_en_r);
  assign rank_waddr = (state_r == S_INIT) ? scan_cnt_r[IDX_W-1:0] : cmp_idx_r;

  always_comb begin
    if (state_r == S_INIT) begin
      rank_wdata = scan_cnt_r[IDX_W-1:0];
    end else if (cmp_idx_r == slot_sel) begin
      rank_wdata = '0;
    end else if (rank_rdata < promo_rank) begin
      rank_wdata = rank_rdata + IDX_W'(1);
    end else begin
      rank_wdata = rank_rdata;
    end
  end

  assign stat_we = (state_r == S_UPD) || key_we;
  assign stat_wdata = (state_r == S_UPD) ?
                      {stat_rdata[127:64] + 64'd1, stat_rdata[63:0] + 64'(rtt_r)} :
                      {64'd1, 64'(rtt_r)};
  assign bkt_raddr = row_base + BA_W'(bucket_r);
  assign bkt_we = (state_r == S_UPD) || (state_r == S_CLR);
  assign bkt_waddr = (state_r == S_CLR) ? row_base + BA_W'(clr_cnt_r) : bkt_raddr;
  // A new entry's row is zero apart from the chosen bucket, which starts at one.
  assign bkt_wdata = (state_r == S_UPD) ? bkt_rdata + 64'd1 :
                     64'(clr_cnt_r == bucket_r);

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    bucket_nxt = bucket_r;
    rtt_nxt = rtt_r;
    scan_cnt_nxt = scan_cnt_r;
    cmp_en_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    hit_nxt = hit_r;
    hit_slot_nxt = hit_slot_r;
    old_rank_nxt = old_rank_r;
    victim_nxt = victim_r;
    victim_valid_nxt = victim_valid_r;
    clr_cnt_nxt = clr_cnt_r;
    res_samples_nxt = res_samples_r;
    res_sum_nxt = res_sum_r;
    res_status_nxt = res_status_r;
    valid_nxt = valid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          state_nxt = S_PREP;
        end
      end
      S_INIT: begin
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_cnt_r == (IDX_W + 1)'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_PREP: begin
        rtt_nxt = prep.rtt_us;
        if (32'(prep.bucket_raw) >= HIST_BUCKETS) begin
          bucket_nxt = BKT_W'(HIST_BUCKETS - 1);
        end else begin
          bucket_nxt = BKT_W'(prep.bucket_raw);
        end
        scan_cnt_nxt = '0;
        hit_nxt = 1'b0;
        clr_cnt_nxt = '0;
        if (prep.drop) begin
          res_status_nxt = ST_DROP;
          res_samples_nxt = '0;
          res_sum_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt_r != (IDX_W + 1)'(TABLE_ENTRIES)) begin
          cmp_en_nxt = 1'b1;
          cmp_idx_nxt = scan_cnt_r[IDX_W-1:0];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
        if (cmp_en_r) begin
          if (valid_r[cmp_idx_r] && (key_rdata == key_word) && !hit_r) begin
            hit_nxt = 1'b1;
            hit_slot_nxt = cmp_idx_r;
            old_rank_nxt = rank_rdata;
          end
          if (rank_rdata == IDX_W'(TABLE_ENTRIES - 1)) begin
            victim_nxt = cmp_idx_r;
            victim_valid_nxt = valid_r[cmp_idx_r];
          end
          if (cmp_idx_r == IDX_W'(TABLE_ENTRIES - 1)) begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        scan_cnt_nxt = '0;
        state_nxt = hit_r ? S_UPD : S_CLR;
      end
      S_UPD: begin
        res_status_nxt = ST_UPDATE;
        res_samples_nxt = stat_rdata[127:64] + 64'd1;
        res_sum_nxt = stat_rdata[63:0] + 64'(rtt_r);
        state_nxt = S_LRU;
      end
      S_CLR: begin
        res_status_nxt = victim_valid_r ? ST_EVICT : ST_INSERT;
        res_samples_nxt = 64'd1;
        res_sum_nxt = 64'(rtt_r);
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == BKT_W'(HIST_BUCKETS - 1)) begin
          state_nxt = S_LRU;
        end
      end
      S_LRU: begin
        // Sweep every rank: the used entry moves to the front and those ahead of it age.
        if (scan_cnt_r != (IDX_W + 1)'(TABLE_ENTRIES)) begin
          cmp_en_nxt = 1'b1;
          cmp_idx_nxt = scan_cnt_r[IDX_W-1:0];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
        if (cmp_en_r && (cmp_idx_r == IDX_W'(TABLE_ENTRIES - 1))) begin
          valid_nxt[slot_sel] = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.status = res_status_r;
          out_data_nxt.bucket = (res_status_r == ST_DROP) ? '0 : BUCKET_W'(bucket_r);
          out_data_nxt.sample_count = res_samples_r;
          out_data_nxt.rtt_sum_us = res_sum_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      scan_cnt_r <= '0;
      cmp_en_r <= 1'b0;
      hit_r <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      cmp_en_r <= cmp_en_nxt;
      hit_r <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r <= valid_nxt;
    end
    req_r <= req_nxt;
    bucket_r <= bucket_nxt;
    rtt_r <= rtt_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_slot_r <= hit_slot_nxt;
    old_rank_r <= old_rank_nxt;
    victim_r <= victim_nxt;
    victim_valid_r <= victim_valid_nxt;
    clr_cnt_r <= clr_cnt_nxt;
    res_samples_r <= res_samples_nxt;
    res_sum_r <= res_sum_nxt;
    res_status_r <= res_status_nxt;
    out_data_r <= out_data_nxt;
  end

  // Entries are never invalidated once filled.
  a_valid_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) >= $past($countones(valid_r)))
    else $error("table entry lost its valid bit");

  // The entry just used is written back as the most recent one.
  a_promoted_front: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_LRU) && cmp_en_r && (cmp_idx_r == slot_sel)) |->
    (rank_we && (rank_wdata == '0)))
    else $error("used entry not written at rank zero");

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");

  // A dropped sample reports nothing but its status.
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == ST_DROP)) |->
    ((out_data_r.bucket == '0) && (out_data_r.sample_count == '0) &&
     (out_data_r.rtt_sum_us == '0)))
    else $error("dropped sample carries non-zero fields");

endmodule
